// ----- hdl/rspc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rspc_pkg
// Shared types, register codes and reset values of the ramped servo pulse
// controller.
// ----------------------------------------------------------------------------
package rspc_pkg;

    localparam int NUM_SLOTS   = 4;
    localparam int SLOT_W      = 2;
    localparam int POS_W       = 16;
    localparam int REST_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int DEF_CHANNELS = 4;

    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [REST_W-1:0] rest_t;
    typedef logic [SLOT_W-1:0] slot_t;

    typedef enum logic [1:0] {
        CMD_MOVE   = 2'd0,
        CMD_ENABLE = 2'd1,
        CMD_PLACE  = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOT_LEN  = 3'd0,
        REG_STEP_CH0  = 3'd1,
        REG_STEP_CH1  = 3'd2,
        REG_STEP_CH2  = 3'd3,
        REG_STEP_CH3  = 3'd4,
        REG_ES_MASK   = 3'd5,
        REG_ES_FRAMES = 3'd6,
        REG_DIRECT    = 3'd7
    } cfg_idx_t;

    localparam pos_t  SLOT_LEN_RST  = 16'd5000;
    localparam pos_t  STEP_RST      = 16'd1;
    localparam rest_t ES_FRAMES_RST = 8'd50;

    // Per-channel ramp controls and status
    typedef struct packed {
        logic  enabled;
        logic  es_on;
        rest_t es_frames;
    } ramp_ctl_t;

    typedef struct packed {
        logic  stop_set;
        logic  disable_ch;
        rest_t rest_next;
    } ramp_stat_t;

endpackage : rspc_pkg
`default_nettype wire

// ----- hdl/rspc_stream_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rspc stream interfaces
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface rspc_cmd_if;
    logic                  valid;
    logic                  ready;
    logic [1:0]            cmd;
    logic [1:0]            channel;
    logic [15:0]           value;

    modport source (output valid, cmd, channel, value, input ready);
    modport sink   (input valid, cmd, channel, value, output ready);
endinterface : rspc_cmd_if

interface rspc_res_if;
    logic                  valid;
    logic                  ready;
    logic [3:0]            pulse_lines;
    logic [3:0]            enabled_mask;
    logic [3:0]            stopped_mask;
    logic [15:0]           position;

    modport source (output valid, pulse_lines, enabled_mask, stopped_mask, position,
                    input ready);
    modport sink   (input valid, pulse_lines, enabled_mask, stopped_mask, position,
                    output ready);
endinterface : rspc_res_if
`default_nettype wire

// ----- hdl/ramped_servo_pulse_controller.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ramped_servo_pulse_controller
// Four-slot servo pulse generator with per-channel position ramps, advanced
// by microsecond tick beats and steered by move, enable and place commands.
// ----------------------------------------------------------------------------
//
//  channel   role     payload
//  -------   ------   ------------------------------------------------------
//  command   sink     cmd[1:0], channel[1:0], value[15:0]
//  result    source   pulse_lines[3:0], enabled_mask[3:0], stopped_mask[3:0],
//                     position[15:0]
//  cfg_*     write    cfg_we, cfg_index[2:0], cfg_data[15:0]
//
//  Every command beat yields one registered result beat; a beat can be
//  taken in every cycle. The single result register is refilled in the same
//  cycle it drains, so only a stalled result holds off the next command.
//  Reset (rst_n low, asynchronous) clears slot timing, positions, targets and
//  enables, marks all channels stopped and loads register defaults.
//
module ramped_servo_pulse_controller #(
    parameter int CHANNELS = rspc_pkg::DEF_CHANNELS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [rspc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rspc_pkg::CFG_DATA_W-1:0] cfg_data,
    rspc_cmd_if.sink                             command,
    rspc_res_if.source                           result
);
    import rspc_pkg::*;

    // Channels that exist; the others never change and read as zero
    localparam logic [NUM_SLOTS-1:0] PRESENT_MASK =
        NUM_SLOTS'((int'(1) << CHANNELS) - 1);

    // Configuration registers
    pos_t                 slot_len_reg;
    pos_t                 step_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] es_mask_reg;
    rest_t                es_frames_reg;
    logic                 direct_reg;

    // Slot timing and channel state
    slot_t                slot_index_reg, slot_index_next;
    pos_t                 slot_ticks_reg, slot_ticks_next;
    pos_t                 latched_width_reg, latched_width_next;
    logic                 latched_on_reg, latched_on_next;
    pos_t                 cur_reg  [NUM_SLOTS];
    pos_t                 cur_next [NUM_SLOTS];
    pos_t                 tgt_reg  [NUM_SLOTS];
    pos_t                 tgt_next [NUM_SLOTS];
    rest_t                rest_reg  [NUM_SLOTS];
    rest_t                rest_next [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] en_reg, en_next;
    logic [NUM_SLOTS-1:0] stop_reg, stop_next;

    // Result register
    logic                 res_valid_reg;
    logic [NUM_SLOTS-1:0] res_lines_reg;
    logic [NUM_SLOTS-1:0] res_en_reg;
    logic [NUM_SLOTS-1:0] res_stop_reg;
    pos_t                 res_pos_reg;

    logic                 accept;
    cmd_t                 cmd;
    slot_t                ch;
    logic                 ch_present;
    logic                 slot_present;
    logic                 slot_start;
    logic                 ramp_now;
    logic [POS_W:0]       ticks_inc;
    logic [NUM_SLOTS-1:0] lines;
    pos_t                 pos_out;

    pos_t                 ramp_pos  [NUM_SLOTS];
    ramp_stat_t           ramp_stat [NUM_SLOTS];

    // ------------------------------------------------------------------
    // Handshake: take a command beat whenever the result slot is free or
    // drains in this cycle
    // ------------------------------------------------------------------
    assign command.ready = !res_valid_reg || result.ready;
    assign accept        = command.valid && command.ready;

    assign cmd          = cmd_t'(command.cmd);
    assign ch           = command.channel;
    assign ch_present   = int'(ch) < CHANNELS;
    assign slot_present = int'(slot_index_reg) < CHANNELS;
    assign slot_start   = (slot_ticks_reg == '0);
    // ramp every present channel once per frame, as slot 3 opens
    assign ramp_now     = (cmd == CMD_TICK) && slot_start &&
                          (slot_index_reg == slot_t'(NUM_SLOTS - 1));
    assign ticks_inc    = {1'b0, slot_ticks_reg} + 1'b1;

    // ------------------------------------------------------------------
    // Per-channel ramp units
    // ------------------------------------------------------------------
    for (genvar c = 0; c < NUM_SLOTS; c++)
    begin : g_ramp
        ramp_ctl_t ctl;

        assign ctl.enabled   = en_reg[c] && PRESENT_MASK[c];
        assign ctl.es_on     = es_mask_reg[c];
        assign ctl.es_frames = es_frames_reg;

        rspc_ramp u_ramp (
            .pos      (cur_reg[c]),
            .tgt      (tgt_reg[c]),
            .step     (step_reg[c]),
            .rest     (rest_reg[c]),
            .ctl      (ctl),
            .pos_next (ramp_pos[c]),
            .stat     (ramp_stat[c])
        );
    end

    // ------------------------------------------------------------------
    // Slot timing: latch width and pulse gate at slot start, cut the pulse
    // at the slot end. A zero slot length acts as one tick.
    // ------------------------------------------------------------------
    always_comb
    begin
        slot_index_next    = slot_index_reg;
        slot_ticks_next    = slot_ticks_reg;
        latched_width_next = latched_width_reg;
        latched_on_next    = latched_on_reg;
        lines              = '0;
        if (cmd == CMD_TICK)
        begin
            if (slot_start)
            begin
                // latch before the frame ramp moves the position
                latched_width_next = slot_present ? cur_reg[slot_index_reg] : '0;
                latched_on_next    = slot_present &&
                                     (en_reg[slot_index_reg] || direct_reg);
            end
            if (latched_on_next && slot_ticks_reg < latched_width_next)
                lines = NUM_SLOTS'(1) << slot_index_reg;
            if (ticks_inc >= {1'b0, slot_len_reg})
            begin
                slot_ticks_next = '0;
                slot_index_next = slot_index_reg + 1'b1;
            end
            else
            begin
                slot_ticks_next = ticks_inc[POS_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Channel state: frame ramp on tick, otherwise apply the command to the
    // addressed channel
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int c = 0; c < NUM_SLOTS; c++)
        begin
            cur_next[c]  = cur_reg[c];
            tgt_next[c]  = tgt_reg[c];
            rest_next[c] = rest_reg[c];
            en_next[c]   = en_reg[c];
            stop_next[c] = stop_reg[c];
            if (cmd == CMD_TICK)
            begin
                if (ramp_now && PRESENT_MASK[c])
                begin
                    cur_next[c]  = ramp_pos[c];
                    rest_next[c] = ramp_stat[c].rest_next;
                    if (ramp_stat[c].stop_set)
                        stop_next[c] = 1'b1;
                    if (ramp_stat[c].disable_ch)
                        en_next[c] = 1'b0;
                end
            end
            else if (ch_present && ch == slot_t'(c))
            begin
                case (cmd)
                    CMD_MOVE:
                    begin
                        if (direct_reg)
                        begin
                            cur_next[c] = command.value;
                            tgt_next[c] = command.value;
                        end
                        else
                        begin
                            tgt_next[c]  = command.value;
                            rest_next[c] = '0;
                            en_next[c]   = 1'b1;
                            stop_next[c] = 1'b0;
                        end
                    end
                    CMD_ENABLE:
                    begin
                        rest_next[c] = '0;
                        en_next[c]   = command.value[0];
                    end
                    CMD_PLACE:
                    begin
                        cur_next[c]  = command.value;
                        tgt_next[c]  = command.value;
                        rest_next[c] = '0;
                        en_next[c]   = 1'b0;
                        stop_next[c] = 1'b1;
                    end
                    default:
                    begin
                        cur_next[c] = cur_reg[c];
                    end
                endcase
            end
        end
    end

    assign pos_out = ch_present ? cur_next[ch] : '0;

    // ------------------------------------------------------------------
    // State registers: advance only on an accepted beat
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_index_reg    <= '0;
            slot_ticks_reg    <= '0;
            latched_width_reg <= '0;
            latched_on_reg    <= 1'b0;
            en_reg            <= '0;
            stop_reg          <= '1;
            for (int c = 0; c < NUM_SLOTS; c++)
            begin
                cur_reg[c]  <= '0;
                tgt_reg[c]  <= '0;
                rest_reg[c] <= '0;
            end
        end
        else if (accept)
        begin
            slot_index_reg    <= slot_index_next;
            slot_ticks_reg    <= slot_ticks_next;
            latched_width_reg <= latched_width_next;
            latched_on_reg    <= latched_on_next;
            en_reg            <= en_next;
            stop_reg          <= stop_next;
            for (int c = 0; c < NUM_SLOTS; c++)
            begin
                cur_reg[c]  <= cur_next[c];
                tgt_reg[c]  <= tgt_next[c];
                rest_reg[c] <= rest_next[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register: load on accept, drop valid once taken
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_lines_reg <= lines;
            res_en_reg    <= en_next & PRESENT_MASK;
            res_stop_reg  <= stop_next & PRESENT_MASK;
            res_pos_reg   <= pos_out;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.pulse_lines  = res_lines_reg;
    assign result.enabled_mask = res_en_reg;
    assign result.stopped_mask = res_stop_reg;
    assign result.position     = res_pos_reg;

    // ------------------------------------------------------------------
    // Configuration writes; unknown indexes fall through
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_len_reg  <= SLOT_LEN_RST;
            es_mask_reg   <= '0;
            es_frames_reg <= ES_FRAMES_RST;
            direct_reg    <= 1'b0;
            for (int c = 0; c < NUM_SLOTS; c++)
                step_reg[c] <= STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_SLOT_LEN:  slot_len_reg  <= cfg_data;
                REG_STEP_CH0:  step_reg[0]   <= cfg_data;
                REG_STEP_CH1:  step_reg[1]   <= cfg_data;
                REG_STEP_CH2:  step_reg[2]   <= cfg_data;
                REG_STEP_CH3:  step_reg[3]   <= cfg_data;
                REG_ES_MASK:   es_mask_reg   <= cfg_data[NUM_SLOTS-1:0];
                REG_ES_FRAMES: es_frames_reg <= cfg_data[REST_W-1:0];
                REG_DIRECT:    direct_reg    <= cfg_data[0];
                default:       direct_reg    <= direct_reg;
            endcase
        end
    end

endmodule : ramped_servo_pulse_controller
`default_nettype wire

// ----- hdl/rspc_ramp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rspc_ramp
// One channel's frame ramp: step the position toward the target, clamp, and
// count rest frames for energy save.
// ----------------------------------------------------------------------------
module rspc_ramp (
    input  rspc_pkg::pos_t      pos,
    input  rspc_pkg::pos_t      tgt,
    input  rspc_pkg::pos_t      step,
    input  rspc_pkg::rest_t     rest,
    input  rspc_pkg::ramp_ctl_t ctl,
    output rspc_pkg::pos_t      pos_next,
    output rspc_pkg::ramp_stat_t stat
);
    import rspc_pkg::*;

    logic [POS_W:0] sum;
    pos_t           diff;

    assign sum  = {1'b0, pos} + {1'b0, step};
    assign diff = pos - step;

    always_comb
    begin
        pos_next        = pos;
        stat.stop_set   = 1'b0;
        stat.disable_ch = 1'b0;
        stat.rest_next  = rest;
        if (ctl.enabled)
        begin
            if (pos < tgt)
            begin
                // clamp at target, overflow included
                pos_next = (sum > {1'b0, tgt}) ? tgt : sum[POS_W-1:0];
            end
            else if (pos > tgt)
            begin
                pos_next = (step >= pos || diff < tgt) ? tgt : diff;
            end
            else
            begin
                stat.stop_set = 1'b1;
                if (ctl.es_on)
                begin
                    stat.rest_next  = rest + 1'b1;
                    stat.disable_ch = (stat.rest_next == ctl.es_frames);
                end
            end
        end
    end

endmodule : rspc_ramp
`default_nettype wire

// ----- tb/servo_pulse_checker.sv -----
// ----------------------------------------------------------------------------
// servo_pulse_checker
// Watches the command, result and register ports of the ramped servo pulse
// controller. It keeps its own copy of slot timing, positions, targets and
// enables, works out the result of every accepted command beat, and compares
// each result beat with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module servo_pulse_checker #(
    parameter int CHANNELS = rspc_pkg::DEF_CHANNELS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rspc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rspc_pkg::CFG_DATA_W-1:0] cfg_data,
    rspc_cmd_if                             command,
    rspc_res_if                             result,
    output int                              failures,
    output int                              pending
);
    import rspc_pkg::*;

    typedef struct packed {
        logic [3:0] lines;
        logic [3:0] enabled;
        logic [3:0] stopped;
        pos_t       position;
    } servo_report_t;

    // register mirror
    pos_t       slot_len;
    pos_t       ramp_step [4];
    logic [3:0] es_mask;
    rest_t      es_frames;
    logic       direct_on;

    // block state
    slot_t      slot_idx;
    pos_t       slot_cnt;
    pos_t       latch_w;
    logic       latch_on;
    pos_t       srv_pos  [4];
    pos_t       srv_tgt  [4];
    logic [3:0] srv_en;
    logic [3:0] srv_stop;
    rest_t      srv_rest [4];

    servo_report_t due_reports [$];

    function automatic void clear_state();
        slot_len  = SLOT_LEN_RST;
        es_mask   = '0;
        es_frames = ES_FRAMES_RST;
        direct_on = 1'b0;
        slot_idx  = '0;
        slot_cnt  = '0;
        latch_w   = '0;
        latch_on  = 1'b0;
        srv_en    = '0;
        srv_stop  = '1;
        for (int c = 0; c < 4; c++)
        begin
            ramp_step[c] = STEP_RST;
            srv_pos[c]   = '0;
            srv_tgt[c]   = '0;
            srv_rest[c]  = '0;
        end
    endfunction

    function automatic void apply_register(cfg_idx_t idx, pos_t data);
        case (idx)
            REG_SLOT_LEN:  slot_len     = data;
            REG_STEP_CH0:  ramp_step[0] = data;
            REG_STEP_CH1:  ramp_step[1] = data;
            REG_STEP_CH2:  ramp_step[2] = data;
            REG_STEP_CH3:  ramp_step[3] = data;
            REG_ES_MASK:   es_mask      = data[3:0];
            REG_ES_FRAMES: es_frames    = data[7:0];
            REG_DIRECT:    direct_on    = data[0];
            default:       ;
        endcase
    endfunction

    // One frame of ramping: move each enabled channel one step towards its
    // target, or count a rest frame when it is already there.
    function automatic void ramp_frame();
        logic [16:0] up;
        for (int c = 0; c < CHANNELS && c < 4; c++)
        begin
            if (!srv_en[c])
                continue;
            if (srv_pos[c] < srv_tgt[c])
            begin
                up = {1'b0, srv_pos[c]} + {1'b0, ramp_step[c]};
                srv_pos[c] = (up > {1'b0, srv_tgt[c]}) ? srv_tgt[c] : up[15:0];
            end
            else if (srv_pos[c] > srv_tgt[c])
            begin
                if (ramp_step[c] >= srv_pos[c] || srv_pos[c] - ramp_step[c] < srv_tgt[c])
                    srv_pos[c] = srv_tgt[c];
                else
                    srv_pos[c] = srv_pos[c] - ramp_step[c];
            end
            else
            begin
                srv_stop[c] = 1'b1;
                if (es_mask[c])
                begin
                    srv_rest[c] = srv_rest[c] + 8'd1;
                    if (srv_rest[c] == es_frames)
                        srv_en[c] = 1'b0;
                end
            end
        end
    endfunction

    function automatic logic [3:0] run_tick();
        logic [3:0]  lines;
        logic [16:0] next_cnt;
        lines = '0;
        if (slot_cnt == '0)
        begin
            if (int'(slot_idx) < CHANNELS)
            begin
                latch_w  = srv_pos[slot_idx];
                latch_on = srv_en[slot_idx] | direct_on;
            end
            else
            begin
                latch_w  = '0;
                latch_on = 1'b0;
            end
            if (slot_idx == slot_t'(3))
                ramp_frame();
        end
        if (latch_on && slot_cnt < latch_w)
            lines[slot_idx] = 1'b1;
        next_cnt = {1'b0, slot_cnt} + 17'd1;
        if (next_cnt >= {1'b0, slot_len})
        begin
            slot_cnt = '0;
            slot_idx = slot_idx + slot_t'(1);
        end
        else
            slot_cnt = next_cnt[15:0];
        return lines;
    endfunction

    function automatic servo_report_t predict_beat(cmd_t op, logic [1:0] ch, pos_t val);
        servo_report_t rep;
        logic          present;
        rep     = '0;
        present = int'(ch) < CHANNELS;
        if (op == CMD_TICK)
            rep.lines = run_tick();
        else if (present)
        begin
            case (op)
                CMD_MOVE:
                    if (direct_on)
                    begin
                        srv_pos[ch] = val;
                        srv_tgt[ch] = val;
                    end
                    else
                    begin
                        srv_tgt[ch]  = val;
                        srv_rest[ch] = '0;
                        srv_en[ch]   = 1'b1;
                        srv_stop[ch] = 1'b0;
                    end
                CMD_ENABLE:
                begin
                    srv_rest[ch] = '0;
                    srv_en[ch]   = val[0];
                end
                default:
                begin
                    srv_pos[ch]  = val;
                    srv_tgt[ch]  = val;
                    srv_rest[ch] = '0;
                    srv_en[ch]   = 1'b0;
                    srv_stop[ch] = 1'b1;
                end
            endcase
        end
        for (int c = 0; c < CHANNELS && c < 4; c++)
        begin
            rep.enabled[c] = srv_en[c];
            rep.stopped[c] = srv_stop[c];
        end
        rep.position = present ? srv_pos[ch] : '0;
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        servo_report_t seen;
        servo_report_t want;
        if (!rst_n)
        begin
            clear_state();
            due_reports.delete();
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            // compare first: a result beat always belongs to an earlier command
            if (result.valid && result.ready)
            begin
                seen = {result.pulse_lines, result.enabled_mask,
                        result.stopped_mask, result.position};
                if (due_reports.size() == 0)
                begin
                    if (failures < 10)
                        $display("servo checker: unexpected result beat lines %h en %h stop %h pos %h",
                                 seen.lines, seen.enabled, seen.stopped, seen.position);
                    failures <= failures + 1;
                end
                else
                begin
                    want = due_reports.pop_front();
                    if (seen !== want)
                    begin
                        if (failures < 10)
                            $display({"servo checker: mismatch (expected/actual) lines %h/%h ",
                                      "en %h/%h stop %h/%h pos %h/%h"},
                                     want.lines, seen.lines, want.enabled, seen.enabled,
                                     want.stopped, seen.stopped, want.position, seen.position);
                        failures <= failures + 1;
                    end
                end
            end
            if (cfg_we)
                apply_register(cfg_idx_t'(cfg_index), cfg_data);
            if (command.valid && command.ready)
                due_reports.push_back(predict_beat(cmd_t'(command.cmd), command.channel,
                                                   command.value));
            pending <= due_reports.size();
        end
    end

endmodule : servo_pulse_checker

// ----- tb/ramped_servo_pulse_controller_test.sv -----
// ----------------------------------------------------------------------------
// ramped_servo_pulse_controller_test
// Drives the servo pulse controller through a directed opening and a series
// of randomised phases, each under its own register setting, while a checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module ramped_servo_pulse_controller_test;
    import rspc_pkg::*;

    // One complete register setting, written as a batch while the block idles
    typedef struct {
        pos_t       slot_len;
        pos_t       step [4];
        logic [3:0] es_mask;
        rest_t      es_frames;
        logic       direct;
    } servo_setup_t;

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int failures;
    int pending;
    int stall_pct;
    int stall_left;

    rspc_cmd_if command_ch ();
    rspc_res_if result_ch ();

    always #5 clk = ~clk;

    ramped_servo_pulse_controller #(
        .CHANNELS (DEF_CHANNELS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .command   (command_ch),
        .result    (result_ch)
    );

    servo_pulse_checker #(
        .CHANNELS (DEF_CHANNELS)
    ) watcher (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .command   (command_ch),
        .result    (result_ch),
        .failures  (failures),
        .pending   (pending)
    );

    // Result side: hold ready low in bursts of random length; the odds come
    // from the current phase, and a zero rate keeps ready high throughout.
    always @(posedge clk or negedge rst_n)
    begin : result_sink
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= 0;
        end
        else if (stall_left > 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= stall_left - 1;
        end
        else if (stall_pct > 0 && $urandom_range(99, 0) < stall_pct)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= $urandom_range(4, 0);
        end
        else
            result_ch.ready <= 1'b1;
    end

    // Write one register; the enable is left high so that back-to-back
    // writes never lower and raise it in the same step.
    task automatic write_reg(cfg_idx_t idx, pos_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic write_setup(servo_setup_t s);
        write_reg(REG_SLOT_LEN, s.slot_len);
        for (int c = 0; c < 4; c++)
            write_reg(cfg_idx_t'(REG_STEP_CH0 + c), s.step[c]);
        write_reg(REG_ES_MASK, pos_t'(s.es_mask));
        write_reg(REG_ES_FRAMES, pos_t'(s.es_frames));
        write_reg(REG_DIRECT, pos_t'(s.direct));
        cfg_we <= 1'b0;
    endtask

    // Offer one command beat and return just after the edge that takes it.
    // Valid stays high so the next beat can follow without a gap.
    task automatic send_beat(cmd_t op, logic [1:0] ch, pos_t val);
        command_ch.valid   <= 1'b1;
        command_ch.cmd     <= op;
        command_ch.channel <= ch;
        command_ch.value   <= val;
        do
            @(posedge clk);
        while (!command_ch.ready);
    endtask

    task automatic pause(int cycles);
        command_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drop valid and wait until every expected result beat has arrived, then
    // let the result register settle.
    task automatic drain();
        command_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (3) @(posedge clk);
    endtask

    // Positions: mostly near the slot lengths in use so that pulses are both
    // narrower and wider than a slot, with rail values and full-range noise.
    function automatic pos_t random_value();
        case ($urandom_range(3, 0))
            0:       return pos_t'($urandom_range(12, 0));
            1:       return pos_t'($urandom_range(60, 0));
            2:       return $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
            default: return pos_t'($urandom());
        endcase
    endfunction

    function automatic servo_setup_t random_setup();
        servo_setup_t s;
        s.slot_len = pos_t'($urandom_range(8, 1));
        for (int c = 0; c < 4; c++)
        begin
            case ($urandom_range(3, 0))
                0:       s.step[c] = pos_t'($urandom_range(3, 0));
                1:       s.step[c] = pos_t'($urandom_range(50, 1));
                2:       s.step[c] = pos_t'($urandom());
                default: s.step[c] = 16'hFFFF;
            endcase
        end
        s.es_mask   = 4'($urandom());
        s.es_frames = ($urandom_range(3, 0) == 0) ? rest_t'($urandom())
                                                  : rest_t'($urandom_range(4, 1));
        s.direct    = ($urandom_range(3, 0) == 0);
        return s;
    endfunction

    // Mostly tick beats so that frames roll over and ramps progress, with
    // commands mixed in. A channel-0 spare keeps commands off channel 0 for
    // long rest counts; drain_at asks for a full drain part way through.
    task automatic random_phase(int beats, int cmd_pct, int idle_pct, bit spare_ch0,
                                int drain_at);
        cmd_t       op;
        logic [1:0] ch;
        stall_pct = idle_pct;
        for (int n = 0; n < beats; n++)
        begin
            if (n == drain_at)
                drain();
            if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct)
                pause($urandom_range(5, 1));
            op = ($urandom_range(99, 0) < cmd_pct) ? cmd_t'($urandom_range(2, 0)) : CMD_TICK;
            ch = (spare_ch0 && op != CMD_TICK) ? 2'($urandom_range(3, 1))
                                               : 2'($urandom_range(3, 0));
            send_beat(op, ch, random_value());
        end
    endtask

    initial
    begin : stimulus
        servo_setup_t setup;

        cfg_we             <= 1'b0;
        cfg_index          <= REG_SLOT_LEN;
        cfg_data           <= '0;
        command_ch.valid   <= 1'b0;
        command_ch.cmd     <= CMD_TICK;
        command_ch.channel <= '0;
        command_ch.value   <= '0;
        stall_pct = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: three-tick slots, steps at both rails and zero,
        // energy save with a one-frame limit on channel 2.
        setup.slot_len  = 16'd3;
        setup.step      = '{16'd1, 16'd100, 16'hFFFF, 16'd0};
        setup.es_mask   = 4'b0100;
        setup.es_frames = 8'd1;
        setup.direct    = 1'b0;
        write_setup(setup);

        // Place every channel: rail positions and one wider than the slot
        send_beat(CMD_PLACE, 2'd0, 16'h0000);
        send_beat(CMD_PLACE, 2'd1, 16'hFFFF);
        send_beat(CMD_PLACE, 2'd2, 16'h0002);
        send_beat(CMD_PLACE, 2'd3, 16'h0004);
        // Moves: slow ramp up, ramp down, overflowing step that clamps at
        // the target, and a zero step that never arrives
        send_beat(CMD_MOVE, 2'd0, 16'h0005);
        send_beat(CMD_MOVE, 2'd1, 16'h0000);
        send_beat(CMD_MOVE, 2'd2, 16'hFFFF);
        send_beat(CMD_MOVE, 2'd3, 16'h0009);
        // Enable takes only bit 0 of the value
        send_beat(CMD_ENABLE, 2'd1, 16'hFFFE);
        send_beat(CMD_ENABLE, 2'd1, 16'h0001);
        // Run past a frame boundary so ramps, clamps and wide pulses show
        for (int n = 0; n < 14; n++)
            send_beat(CMD_TICK, 2'(n), 16'h0000);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            setup = random_setup();
            case (p)
                0:
                begin
                    // shortest real slot, unit steps, every channel saving
                    setup.slot_len  = 16'd1;
                    setup.step      = '{default: 16'd1};
                    setup.es_mask   = 4'hF;
                    setup.es_frames = 8'd1;
                    setup.direct    = 1'b0;
                end
                1:
                begin
                    // longest slot and zero steps: ramps never move a position
                    setup.slot_len  = 16'hFFFF;
                    setup.step      = '{default: 16'd0};
                    setup.es_mask   = 4'h0;
                    setup.es_frames = 8'hFF;
                    setup.direct    = 1'b0;
                end
                2:
                begin
                    // zero slot length and a zero rest limit (wraps at 256)
                    setup.slot_len  = 16'd0;
                    setup.es_mask   = 4'b0001;
                    setup.es_frames = 8'd0;
                    setup.direct    = 1'b0;
                end
                3:
                begin
                    // full-scale steps: ramps overshoot both ways and clamp
                    setup.slot_len = 16'd2;
                    setup.step     = '{default: 16'hFFFF};
                    setup.direct   = 1'b0;
                end
                4:
                    setup.direct = 1'b1;
                default:
                    ;
            endcase
            write_setup(setup);

            case (p)
                0: random_phase(80, 20, 20, 1'b0, -1);
                1: random_phase(60, 30, 0, 1'b0, -1);
                2:
                begin
                    // Park channel 0 at its target and enabled, then leave it
                    // alone for more than 256 frames of single-tick slots
                    send_beat(CMD_PLACE, 2'd0, 16'h0000);
                    send_beat(CMD_ENABLE, 2'd0, 16'h0001);
                    random_phase(1100, 3, 10, 1'b1, -1);
                end
                3: random_phase(80, 20, 25, 1'b0, 40);
                4: random_phase(80, 20, 0, 1'b0, -1);
                5: random_phase(80, 20, 30, 1'b0, -1);
                6: random_phase(80, 20, 15, 1'b0, -1);
                default: random_phase(80, 20, 0, 1'b0, -1);
            endcase
            drain();
        end

        if (failures == 0 && pending == 0)
            $display("[ramped_servo_pulse_controller] OK");
        else
            $display("[ramped_servo_pulse_controller] ERROR");
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin : watchdog
        #4_000_000;
        $display("[ramped_servo_pulse_controller] ERROR");
        $finish;
    end

endmodule : ramped_servo_pulse_controller_test
